// ----- design/i2cm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared command codes and the queued word format of the I2C byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int CMD_W = 3;

    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WAIT  = 3'd5;

    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    // One classified word, as handed from the front to the back.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [7:0]       tx_byte;
        logic             send_ack;
        logic             sda_in;
    } item_t;

endpackage

// ----- design/i2cm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_front
// Accept input words, fold unknown commands into ticks, and queue them.
// ----------------------------------------------------------------------------
module i2cm_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  i2cm_pkg::item_t in_item,
    output logic           q_valid,
    input  logic           q_pop,
    output i2cm_pkg::item_t q_item
);

    i2cm_pkg::item_t ent_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    i2cm_pkg::item_t cls_item;
    logic            push;
    logic            pop;

    // Codes outside the command list behave as ticks.
    always_comb
    begin
        cls_item = in_item;
        if (in_item.command > i2cm_pkg::CMD_WAIT)
        begin
            cls_item.command = i2cm_pkg::CMD_TICK;
        end
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = ent_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= cls_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/i2cm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_back
// Phase sequencer: one word per cycle, unless stalled, to a registered result.
// ----------------------------------------------------------------------------
module i2cm_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_pop,
    input  i2cm_pkg::item_t q_item,
    input  logic            cfg_we,
    input  logic [7:0]      cfg_value,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [15:0]     out_data
);

    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_ST_A    = 5'd1;
    localparam logic [4:0] PH_ST_B    = 5'd2;
    localparam logic [4:0] PH_SP_A    = 5'd3;
    localparam logic [4:0] PH_SP_B    = 5'd4;
    localparam logic [4:0] PH_WA_A    = 5'd5;
    localparam logic [4:0] PH_WA_POLL = 5'd6;
    localparam logic [4:0] PH_WR_HIGH = 5'd7;
    localparam logic [4:0] PH_WR_LOW  = 5'd8;
    localparam logic [4:0] PH_RD_LOW  = 5'd9;
    localparam logic [4:0] PH_RD_HIGH = 5'd10;
    localparam logic [4:0] PH_AK_LOW  = 5'd11;
    localparam logic [4:0] PH_AK_HIGH = 5'd12;

    localparam logic [3:0] BYTE_BITS = 4'd8;

    logic [7:0]  timeout_reg;
    logic [4:0]  phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  poll_reg, poll_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        drive_reg, drive_next;
    logic        ack_choice_reg, ack_choice_next;
    logic        error_reg, error_next;
    logic [7:0]  rx_reg, rx_next;
    logic        done_next;
    logic [7:0]  rd_shift;
    logic [3:0]  rd_count;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;

    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign rd_shift  = {shift_reg[6:0], q_item.sda_in};
    assign rd_count  = bit_count_reg + 4'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        poll_next       = poll_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        drive_next      = drive_reg;
        ack_choice_next = ack_choice_reg;
        error_next      = error_reg;
        rx_next         = rx_reg;
        done_next       = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            unique case (q_item.command)
                i2cm_pkg::CMD_START:
                begin
                    drive_next = 1'b1;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    phase_next = PH_ST_A;
                end
                i2cm_pkg::CMD_STOP:
                begin
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    phase_next = PH_SP_A;
                end
                i2cm_pkg::CMD_WRITE:
                begin
                    // Load the byte and put out its MSB at once.
                    drive_next     = 1'b1;
                    sda_next       = q_item.tx_byte[7];
                    shift_next     = {q_item.tx_byte[6:0], 1'b0};
                    bit_count_next = 4'd1;
                    scl_next       = 1'b1;
                    phase_next     = PH_WR_HIGH;
                end
                i2cm_pkg::CMD_READ:
                begin
                    drive_next      = 1'b0;
                    scl_next        = 1'b0;
                    shift_next      = 8'd0;
                    bit_count_next  = 4'd0;
                    ack_choice_next = q_item.send_ack;
                    phase_next      = PH_RD_LOW;
                end
                i2cm_pkg::CMD_WAIT:
                begin
                    drive_next = 1'b1;
                    sda_next   = 1'b1;
                    poll_next  = 8'd0;
                    error_next = 1'b0;
                    phase_next = PH_WA_A;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_ST_A:
                begin
                    sda_next   = 1'b0;
                    phase_next = PH_ST_B;
                end
                PH_ST_B:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_SP_A:
                begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_SP_B;
                end
                PH_SP_B:
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_WA_A:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_WA_POLL;
                end
                PH_WA_POLL:
                begin
                    drive_next = 1'b0;
                    priority if (!q_item.sda_in)
                    begin
                        scl_next   = 1'b0;
                        error_next = 1'b0;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    else if (poll_reg >= timeout_reg)
                    begin
                        // Give up: flag the error and run a stop.
                        error_next = 1'b1;
                        drive_next = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        phase_next = PH_SP_A;
                    end
                    else
                    begin
                        poll_next = poll_reg + 8'd1;
                    end
                end
                PH_WR_HIGH:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_WR_LOW;
                end
                PH_WR_LOW:
                begin
                    if (bit_count_reg >= BYTE_BITS)
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        sda_next       = shift_reg[7];
                        shift_next     = {shift_reg[6:0], 1'b0};
                        bit_count_next = bit_count_reg + 4'd1;
                        scl_next       = 1'b1;
                        phase_next     = PH_WR_HIGH;
                    end
                end
                PH_RD_LOW:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_RD_HIGH;
                end
                PH_RD_HIGH:
                begin
                    shift_next     = rd_shift;
                    bit_count_next = rd_count;
                    scl_next       = 1'b0;
                    if (rd_count >= BYTE_BITS)
                    begin
                        rx_next    = rd_shift;
                        drive_next = 1'b1;
                        sda_next   = ~ack_choice_reg;
                        phase_next = PH_AK_LOW;
                    end
                    else
                    begin
                        phase_next = PH_RD_LOW;
                    end
                end
                PH_AK_LOW:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_AK_HIGH;
                end
                PH_AK_HIGH:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= {2'b00, error_next, rx_next, done_next,
                             (phase_next != PH_IDLE), drive_next, sda_next, scl_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= i2cm_pkg::ACK_TIMEOUT_RESET;
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            poll_reg       <= 8'd0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            drive_reg      <= 1'b1;
            ack_choice_reg <= 1'b0;
            error_reg      <= 1'b0;
            rx_reg         <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_value;
            end
            if (q_pop)
            begin
                phase_reg      <= phase_next;
                bit_count_reg  <= bit_count_next;
                shift_reg      <= shift_next;
                poll_reg       <= poll_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                drive_reg      <= drive_next;
                ack_choice_reg <= ack_choice_next;
                error_reg      <= error_next;
                rx_reg         <= rx_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- design/i2c_master_byte_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master bit-level controller: SCL/SDA phase sequencer, one phase a word.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake              Payload
// s_axis    in   s_axis_tvalid/tready   tuser: command; tdata: tx_byte,
//                                       send_ack, sda_in
// m_axis    out  m_axis_tvalid/tready   tdata: scl, sda_out, sda_drive,
//                                       busy_res, done_res, rx_byte, ack_error
// cfg       in   cfg_valid/cfg_ready    cfg_data: ack_timeout
//
// Every input word yields exactly one result word. The engine takes one word
// per clock unless the output stalls; each word waits in the two-entry front
// queue, then goes through the phase sequencer into the output register.
// The sequencer updates its phase state only when the output register is free
// or being drained, so an output stall backs up into the queue and then into
// s_axis_tready. Reset empties the queue, returns the bus to idle with SCL and
// SDA high and driven, and loads ack_timeout with 250.
// cfg_ready is always high; write ack_timeout only while the engine is idle.
//
module i2c_master_byte_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] tx_byte, [8] send_ack, [9] sda_in
    input  logic [2:0]  s_axis_tuser,   // [2:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] scl, [1] sda_out, [2] sda_drive,
                                        // [3] busy_res, [4] done_res,
                                        // [12:5] rx_byte, [13] ack_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    i2cm_pkg::item_t in_item;
    i2cm_pkg::item_t q_item;
    logic            q_valid;
    logic            q_pop;

    // Unpack the slave-side word into the item layout.
    assign in_item.command  = s_axis_tuser;
    assign in_item.tx_byte  = s_axis_tdata[7:0];
    assign in_item.send_ack = s_axis_tdata[8];
    assign in_item.sda_in   = s_axis_tdata[9];

    assign cfg_ready = 1'b1;

    // Front: classify and queue incoming words.
    i2cm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    // Back: advance bus phases and hold the result word.
    i2cm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_value (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ----- design/i2cm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the I2C byte engine result stream.
// ----------------------------------------------------------------------------
module i2cm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A stalled result word stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // Completion returns the bus to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[3])
        else $error("done with busy still set");

    // Only a stop ends with SCL high, and it leaves SDA driven high.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4] && m_axis_tdata[0]
        |-> m_axis_tdata[1] && m_axis_tdata[2])
        else $error("sequence ended with SCL high but no stop condition");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C master byte engine. A table of
// hand-checked words covers the bus sequences and corner cases. Random
// command traffic follows under several ACK timeout settings. Every result
// word is checked against an in-bench SCL/SDA sequencer model or a typed value.
// ----------------------------------------------------------------------------
module testbench;

    // Command codes the engine must ignore
    localparam logic [i2cm_pkg::CMD_W-1:0] CMD_RSVD_A = 3'd6;
    localparam logic [i2cm_pkg::CMD_W-1:0] CMD_RSVD_B = 3'd7;
    localparam int BYTE_BITS = 8;
    localparam int DRAIN_CYCLES = 4;
    localparam int WORDS_PER_SETTING = 425;

    typedef enum logic [4:0] {
        SEQ_IDLE, SEQ_START_A, SEQ_START_B, SEQ_STOP_A, SEQ_STOP_B,
        SEQ_WAIT_A, SEQ_WAIT_POLL, SEQ_WR_HIGH, SEQ_WR_LOW,
        SEQ_RD_LOW, SEQ_RD_HIGH, SEQ_ACK_LOW, SEQ_ACK_HIGH
    } seq_phase_t;

    // One result word, fields in output order
    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack_error;
    } bus_result_t;

    // One line of the directed table; want is used only when typed is set
    typedef struct {
        i2cm_pkg::item_t word;
        int              reps;
        bit              typed;
        bus_result_t     want;
    } step_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = i2cm_pkg::CMD_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    // Model of the engine state
    seq_phase_t  eng_phase = SEQ_IDLE;
    logic [3:0]  eng_bits = '0;
    logic [7:0]  eng_shift = '0;
    logic [7:0]  eng_polls = '0;
    logic        eng_scl = 1'b1;
    logic        eng_sda = 1'b1;
    logic        eng_drive = 1'b1;
    logic        eng_ack_sel = 1'b0;
    logic        eng_err = 1'b0;
    logic [7:0]  eng_rx = '0;
    logic [7:0]  eng_timeout = i2cm_pkg::ACK_TIMEOUT_RESET;

    bus_result_t bus_expect [$];
    int          fail_count = 0;
    int          sink_hold = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    step_row_t   script [24];
    int          timeouts [4];

    always #5 clk = ~clk;

    i2c_master_byte_engine dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------------

    // Present the next MSB on SDA and raise SCL
    function automatic void shift_out_bit();
        eng_sda = eng_shift[7];
        eng_shift = {eng_shift[6:0], 1'b0};
        eng_bits = eng_bits + 4'd1;
        eng_scl = 1'b1;
    endfunction

    // SCL low, SDA driven low: first half of a stop condition
    function automatic void enter_stop();
        eng_drive = 1'b1;
        eng_scl = 1'b0;
        eng_sda = 1'b0;
        eng_phase = SEQ_STOP_A;
    endfunction

    function automatic bus_result_t step_engine(input i2cm_pkg::item_t w);
        bus_result_t r;
        logic        fin;
        fin = 1'b0;
        if (eng_phase == SEQ_IDLE)
        begin
            // Commands are taken only here; a tick or an unused code is a no-op
            case (w.command)
                i2cm_pkg::CMD_START:
                begin
                    eng_drive = 1'b1;
                    eng_sda = 1'b1;
                    eng_scl = 1'b1;
                    eng_phase = SEQ_START_A;
                end
                i2cm_pkg::CMD_STOP:
                    enter_stop();
                i2cm_pkg::CMD_WRITE:
                begin
                    eng_drive = 1'b1;
                    eng_shift = w.tx_byte;
                    eng_bits = '0;
                    shift_out_bit();
                    eng_phase = SEQ_WR_HIGH;
                end
                i2cm_pkg::CMD_READ:
                begin
                    eng_drive = 1'b0;
                    eng_scl = 1'b0;
                    eng_shift = '0;
                    eng_bits = '0;
                    eng_ack_sel = w.send_ack;
                    eng_phase = SEQ_RD_LOW;
                end
                i2cm_pkg::CMD_WAIT:
                begin
                    eng_drive = 1'b1;
                    eng_sda = 1'b1;
                    eng_polls = '0;
                    eng_err = 1'b0;
                    eng_phase = SEQ_WAIT_A;
                end
                default:
                    ;
            endcase
        end
        else
        begin
            // Busy: any word, command or not, advances the sequence one step
            case (eng_phase)
                SEQ_START_A:
                begin
                    eng_sda = 1'b0;
                    eng_phase = SEQ_START_B;
                end
                SEQ_START_B:
                begin
                    eng_scl = 1'b0;
                    eng_phase = SEQ_IDLE;
                    fin = 1'b1;
                end
                SEQ_STOP_A:
                begin
                    eng_scl = 1'b1;
                    eng_sda = 1'b1;
                    eng_phase = SEQ_STOP_B;
                end
                SEQ_STOP_B:
                begin
                    eng_phase = SEQ_IDLE;
                    fin = 1'b1;
                end
                SEQ_WAIT_A:
                begin
                    eng_scl = 1'b1;
                    eng_phase = SEQ_WAIT_POLL;
                end
                SEQ_WAIT_POLL:
                begin
                    eng_drive = 1'b0;
                    if (!w.sda_in)
                    begin
                        eng_scl = 1'b0;
                        eng_err = 1'b0;
                        eng_phase = SEQ_IDLE;
                        fin = 1'b1;
                    end
                    else if (eng_polls >= eng_timeout)
                    begin
                        // Give up: flag now, done comes at the end of the stop
                        eng_err = 1'b1;
                        enter_stop();
                    end
                    else
                    begin
                        eng_polls = eng_polls + 8'd1;
                    end
                end
                SEQ_WR_HIGH:
                begin
                    eng_scl = 1'b0;
                    eng_phase = SEQ_WR_LOW;
                end
                SEQ_WR_LOW:
                begin
                    if (eng_bits >= BYTE_BITS)
                    begin
                        eng_phase = SEQ_IDLE;
                        fin = 1'b1;
                    end
                    else
                    begin
                        shift_out_bit();
                        eng_phase = SEQ_WR_HIGH;
                    end
                end
                SEQ_RD_LOW:
                begin
                    eng_scl = 1'b1;
                    eng_phase = SEQ_RD_HIGH;
                end
                SEQ_RD_HIGH:
                begin
                    // Sample SDA at the end of the high phase
                    eng_shift = {eng_shift[6:0], w.sda_in};
                    eng_bits = eng_bits + 4'd1;
                    eng_scl = 1'b0;
                    if (eng_bits >= BYTE_BITS)
                    begin
                        eng_rx = eng_shift;
                        eng_drive = 1'b1;
                        eng_sda = !eng_ack_sel;
                        eng_phase = SEQ_ACK_LOW;
                    end
                    else
                    begin
                        eng_phase = SEQ_RD_LOW;
                    end
                end
                SEQ_ACK_LOW:
                begin
                    eng_scl = 1'b1;
                    eng_phase = SEQ_ACK_HIGH;
                end
                SEQ_ACK_HIGH:
                begin
                    eng_scl = 1'b0;
                    eng_phase = SEQ_IDLE;
                    fin = 1'b1;
                end
                default:
                    eng_phase = SEQ_IDLE;
            endcase
        end
        r.scl = eng_scl;
        r.sda_out = eng_sda;
        r.sda_drive = eng_drive;
        r.busy = (eng_phase != SEQ_IDLE);
        r.done = fin;
        r.rx_byte = eng_rx;
        r.ack_error = eng_err;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driving side
    // ------------------------------------------------------------------------

    // Offer one word, hold it until taken, then log what it should produce.
    // A typed word replaces the model's answer with a hand-checked one.
    task automatic push_word(input i2cm_pkg::item_t w, input bit typed,
                             input bus_result_t want);
        int          gap;
        bus_result_t guess;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, w.sda_in, w.send_ack, w.tx_byte};
        s_axis_tuser  <= w.command;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        guess = step_engine(w);
        bus_expect.push_back(typed ? want : guess);
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
    endtask

    // Drop valid and hold until every result is back and the pipe is empty
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (bus_expect.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_timeout(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        eng_timeout = v;
    endtask

    // Random command sequences. Mostly whole sequences clocked out by ticks;
    // a share of stray commands land mid-sequence and must act as ticks.
    task automatic run_traffic(input int n_words);
        i2cm_pkg::item_t w;
        int              sent;
        int              pick;
        int              polls_high;
        sent = 0;
        polls_high = 0;
        while (sent < n_words || eng_phase != SEQ_IDLE)
        begin
            w.tx_byte  = 8'($urandom_range(0, 255));
            w.send_ack = 1'($urandom_range(0, 1));
            w.sda_in   = 1'($urandom_range(0, 1));
            w.command  = i2cm_pkg::CMD_TICK;
            if (eng_phase == SEQ_IDLE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    w.command = i2cm_pkg::CMD_START;
                else if (pick < 45)
                    w.command = i2cm_pkg::CMD_WRITE;
                else if (pick < 70)
                    w.command = i2cm_pkg::CMD_READ;
                else if (pick < 85)
                begin
                    w.command = i2cm_pkg::CMD_WAIT;
                    // Mostly a quick ACK; sometimes run up to and past the timeout
                    if ($urandom_range(0, 9) < 7)
                        polls_high = $urandom_range(0, 3);
                    else
                        polls_high = $urandom_range(0, int'(eng_timeout) + 1);
                end
                else if (pick < 95)
                    w.command = i2cm_pkg::CMD_STOP;
            end
            else if ($urandom_range(0, 99) < 8)
            begin
                w.command = 3'($urandom_range(i2cm_pkg::CMD_START, i2cm_pkg::CMD_WAIT));
            end
            else if (eng_phase == SEQ_WAIT_POLL)
            begin
                w.sda_in = (polls_high != 0);
                if (polls_high != 0)
                    polls_high--;
            end
            push_word(w, 1'b0, '0);
            sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls on tready, field-by-field check
    // ------------------------------------------------------------------------

    function automatic void match_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_sink
        bus_result_t seen;
        bus_result_t due;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_hold = 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            seen.scl       = m_axis_tdata[0];
            seen.sda_out   = m_axis_tdata[1];
            seen.sda_drive = m_axis_tdata[2];
            seen.busy      = m_axis_tdata[3];
            seen.done      = m_axis_tdata[4];
            seen.rx_byte   = m_axis_tdata[12:5];
            seen.ack_error = m_axis_tdata[13];
            if (bus_expect.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                due = bus_expect.pop_front();
                match_field("scl", due.scl, seen.scl);
                match_field("sda_out", due.sda_out, seen.sda_out);
                match_field("sda_drive", due.sda_drive, seen.sda_drive);
                match_field("busy_res", due.busy, seen.busy);
                match_field("done_res", due.done, seen.done);
                match_field("rx_byte", due.rx_byte, seen.rx_byte);
                match_field("ack_error", due.ack_error, seen.ack_error);
            end
            sink_hold = rx_calm ? 0 : $urandom_range(0, 8);
            if ($urandom_range(0, 39) == 0)
                rx_calm = !rx_calm;
            m_axis_tready <= (sink_hold == 0);
        end
        else if (!m_axis_tready)
        begin
            if (sink_hold > 0)
                sink_hold--;
            m_axis_tready <= (sink_hold == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------------

    initial
    begin
        // Timeout is 1 through the table so the give-up path is short.
        // Expected outputs: scl, sda_out, sda_drive, busy, done, rx_byte, ack_error
        script = '{
            // idle bus after reset; tick and unused codes change nothing
            '{'{i2cm_pkg::CMD_TICK,  8'h00, 1'b0, 1'b0},  1, 1'b1, '{1, 1, 1, 0, 0, 8'h00, 0}},
            '{'{CMD_RSVD_A,          8'h00, 1'b0, 1'b0},  1, 1'b1, '{1, 1, 1, 0, 0, 8'h00, 0}},
            '{'{CMD_RSVD_B,          8'hFF, 1'b1, 1'b1},  1, 1'b1, '{1, 1, 1, 0, 0, 8'h00, 0}},
            // start; a stop offered mid-start only advances it
            '{'{i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b0},  1, 1'b1, '{1, 1, 1, 1, 0, 8'h00, 0}},
            '{'{i2cm_pkg::CMD_STOP,  8'h00, 1'b0, 1'b0},  1, 1'b1, '{1, 0, 1, 1, 0, 8'h00, 0}},
            '{'{i2cm_pkg::CMD_TICK,  8'h00, 1'b0, 1'b0},  1, 1'b1, '{0, 0, 1, 0, 1, 8'h00, 0}},
            // stop
            '{'{i2cm_pkg::CMD_STOP,  8'h00, 1'b0, 1'b0},  1, 1'b1, '{0, 0, 1, 1, 0, 8'h00, 0}},
            '{'{i2cm_pkg::CMD_TICK,  8'h00, 1'b0, 1'b0},  1, 1'b1, '{1, 1, 1, 1, 0, 8'h00, 0}},
            '{'{i2cm_pkg::CMD_TICK,  8'h00, 1'b0, 1'b0},  1, 1'b1, '{1, 1, 1, 0, 1, 8'h00, 0}},
            // ACK wait with SDA stuck high: one poll allowed, then stop + error
            '{'{i2cm_pkg::CMD_WAIT,  8'h00, 1'b0, 1'b1},  1, 1'b1, '{1, 1, 1, 1, 0, 8'h00, 0}},
            '{'{i2cm_pkg::CMD_TICK,  8'h00, 1'b0, 1'b1},  1, 1'b1, '{1, 1, 1, 1, 0, 8'h00, 0}},
            '{'{i2cm_pkg::CMD_TICK,  8'h00, 1'b0, 1'b1},  1, 1'b1, '{1, 1, 0, 1, 0, 8'h00, 0}},
            '{'{i2cm_pkg::CMD_TICK,  8'h00, 1'b0, 1'b1},  1, 1'b1, '{0, 0, 1, 1, 0, 8'h00, 1}},
            '{'{i2cm_pkg::CMD_TICK,  8'h00, 1'b0, 1'b1},  1, 1'b1, '{1, 1, 1, 1, 0, 8'h00, 1}},
            '{'{i2cm_pkg::CMD_TICK,  8'h00, 1'b0, 1'b1},  1, 1'b1, '{1, 1, 1, 0, 1, 8'h00, 1}},
            // next wait clears the error; slave answers on the first poll
            '{'{i2cm_pkg::CMD_WAIT,  8'h00, 1'b0, 1'b0},  1, 1'b1, '{1, 1, 1, 1, 0, 8'h00, 0}},
            '{'{i2cm_pkg::CMD_TICK,  8'h00, 1'b0, 1'b0},  1, 1'b1, '{1, 1, 1, 1, 0, 8'h00, 0}},
            '{'{i2cm_pkg::CMD_TICK,  8'h00, 1'b0, 1'b0},  1, 1'b1, '{0, 1, 0, 0, 1, 8'h00, 0}},
            // write all ones
            '{'{i2cm_pkg::CMD_WRITE, 8'hFF, 1'b1, 1'b1},  1, 1'b1, '{1, 1, 1, 1, 0, 8'h00, 0}},
            '{'{i2cm_pkg::CMD_TICK,  8'h00, 1'b0, 1'b0}, 15, 1'b0, '0},
            '{'{i2cm_pkg::CMD_TICK,  8'h00, 1'b0, 1'b0},  1, 1'b1, '{0, 1, 1, 0, 1, 8'h00, 0}},
            // read with SDA high throughout, then NACK
            '{'{i2cm_pkg::CMD_READ,  8'h00, 1'b0, 1'b1},  1, 1'b0, '0},
            '{'{i2cm_pkg::CMD_TICK,  8'h00, 1'b0, 1'b1}, 17, 1'b0, '0},
            '{'{i2cm_pkg::CMD_TICK,  8'h00, 1'b0, 1'b1},  1, 1'b1, '{0, 1, 1, 0, 1, 8'hFF, 0}}
        };
        timeouts = '{255, $urandom_range(2, 254), int'(i2cm_pkg::ACK_TIMEOUT_RESET), 1};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_timeout(8'd1);
        foreach (script[i])
            for (int k = 0; k < script[i].reps; k++)
                push_word(script[i].word, script[i].typed, script[i].want);

        // One random run per timeout setting; drain fully before each write
        foreach (timeouts[i])
        begin
            quiesce();
            load_timeout(8'(timeouts[i]));
            run_traffic(WORDS_PER_SETTING);
        end
        quiesce();

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
